FILE: sv/s3pwm_pkg.sv
// Package for the three-phase sine PWM duty unit.
// Holds the item structs, the fixed field widths and the width helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s3pwm_pkg;

    localparam int ANGLE_W    = 32;
    localparam int LEVEL_W    = 7;
    localparam int DT_W       = 8;
    localparam int OUT_W      = 10;
    localparam int SINE_W     = 16;
    localparam int QUOT_W     = 10;
    localparam int LEVEL_GAIN = 5;
    localparam int LEVEL_MAX  = 127;
    localparam int OUT_MAX    = 1023;

    localparam logic [DT_W-1:0] DEADTIME_RESET = 8'd80;
    localparam logic [63:0]     HALF_PI_Q40    = 64'h1921FB54443;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_turns;
        logic [LEVEL_W-1:0]        drive_level;
        logic                      limit_mode;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] duty_a;
        logic [OUT_W-1:0] duty_b;
        logic [OUT_W-1:0] duty_c;
        logic [OUT_W-1:0] low_side_a;
        logic [OUT_W-1:0] low_side_b;
        logic [OUT_W-1:0] low_side_c;
    } out_item_t;

    // bits of the rounded numerator magnitude for a given sine scale
    function automatic int mag_width(input int scale);
        return $clog2(scale * LEVEL_GAIN * LEVEL_MAX + scale / 2 + 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/s3pwm_index.sv
// Angle to table index for the three phases.
// Rounds the angle to the nearest table entry, wraps it and adds the phase offsets.
// Depends on s3pwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s3pwm_index #(
    parameter int TABLE_SIZE = 256
) (
    input  logic signed [s3pwm_pkg::ANGLE_W-1:0] angle_turns,
    output logic [2:0][$clog2(TABLE_SIZE)-1:0]   phase_idx
);

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int TW    = $clog2(TABLE_SIZE + 1);
    localparam int SW    = 16 + TW;
    localparam int OFF_B = TABLE_SIZE / 3;
    localparam int OFF_C = (2 * TABLE_SIZE + 1) / 3;

    logic          neg;
    logic [15:0]   frac;
    logic [SW-1:0] scaled;
    logic [TW-1:0] turn_pos;
    logic [IW-1:0] wrap_pos;
    logic [IW-1:0] base;

    function automatic logic [IW-1:0] add_wrap(input logic [IW-1:0] a,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, a} + {1'b0, off};
        if (sum >= (IW + 1)'(TABLE_SIZE))
        begin
            sum = sum - (IW + 1)'(TABLE_SIZE);
        end
        return sum[IW-1:0];
    endfunction

    // whole turns drop out of the wrap: only the fraction matters
    assign neg      = angle_turns[s3pwm_pkg::ANGLE_W-1];
    assign frac     = neg ? 16'(16'd0 - angle_turns[15:0]) : angle_turns[15:0];
    assign scaled   = SW'(frac) * SW'(TABLE_SIZE) + SW'(32768);
    assign turn_pos = scaled[16 +: TW];
    assign wrap_pos = (turn_pos == TW'(TABLE_SIZE)) ? '0 : turn_pos[IW-1:0];
    assign base     = (neg && (wrap_pos != '0)) ? IW'(TABLE_SIZE) - wrap_pos : wrap_pos;

    assign phase_idx[0] = base;
    assign phase_idx[1] = add_wrap(base, IW'(OFF_B));
    assign phase_idx[2] = add_wrap(base, IW'(OFF_C));

endmodule

`default_nettype wire

FILE: sv/s3pwm_sine.sv
// Sine table lookup and amplitude product for one phase.
// The table is a constant built at elaboration; depends on s3pwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s3pwm_sine #(
    parameter int TABLE_SIZE = 256,
    parameter int SINE_SCALE = 32767
) (
    input  logic [$clog2(TABLE_SIZE)-1:0]                    idx,
    input  logic [s3pwm_pkg::LEVEL_W-1:0]                    drive_level,
    output logic signed [s3pwm_pkg::mag_width(SINE_SCALE):0] numerator
);

    localparam int NW = s3pwm_pkg::mag_width(SINE_SCALE) + 1;
    localparam int GW = s3pwm_pkg::LEVEL_W + 3;
    localparam int PW = s3pwm_pkg::SINE_W + GW + 1;

    logic signed [s3pwm_pkg::SINE_W-1:0] rom [TABLE_SIZE];
    logic signed [s3pwm_pkg::SINE_W-1:0] sine_val;
    logic [GW-1:0]                       gain;
    logic signed [PW-1:0]                product;

    function automatic logic [63:0] sine_mag_q30(input logic [63:0] p);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] negs;
        x    = (p * s3pwm_pkg::HALF_PI_Q40 / TABLE_SIZE + 64'd512) >> 10;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        term = ((term * x2) >> 30) / 6;
        negs = term;
        term = ((term * x2) >> 30) / 20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 42;
        negs = negs + term;
        term = ((term * x2) >> 30) / 72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 110;
        negs = negs + term;
        term = ((term * x2) >> 30) / 156;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 210;
        negs = negs + term;
        term = ((term * x2) >> 30) / 272;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 342;
        negs = negs + term;
        if (negs >= pos)
        begin
            return 64'd0;
        end
        pos = pos - negs;
        if (pos > (64'd1 << 30))
        begin
            pos = 64'd1 << 30;
        end
        return pos;
    endfunction

    function automatic logic signed [s3pwm_pkg::SINE_W-1:0] sine_entry(input int k);
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] mag;
        logic        neg;
        n   = 64'(TABLE_SIZE);
        p   = 64'(k) * 64'd4;
        neg = 1'b0;
        if (p >= 64'd2 * n)
        begin
            neg = 1'b1;
            p   = p - 64'd2 * n;
        end
        if (p > n)
        begin
            p = 64'd2 * n - p;
        end
        if (p == 64'd0)
        begin
            mag = 64'd0;
        end
        else if (p == n)
        begin
            mag = 64'(SINE_SCALE);
        end
        else if (64'd3 * p == n)
        begin
            mag = 64'((SINE_SCALE + 1) / 2);
        end
        else
        begin
            mag = (64'(SINE_SCALE) * sine_mag_q30(p) + (64'd1 << 29)) >> 30;
        end
        return neg ? s3pwm_pkg::SINE_W'(64'd0 - mag) : s3pwm_pkg::SINE_W'(mag);
    endfunction

    genvar k;
    for (k = 0; k < TABLE_SIZE; k++)
    begin : g_rom
        assign rom[k] = sine_entry(k);
    end

    assign sine_val  = rom[idx];
    assign gain      = {1'b0, drive_level, 2'b00} + GW'(drive_level);
    assign product   = PW'(sine_val) * $signed({1'b0, gain});
    assign numerator = NW'(product) + NW'(SINE_SCALE / 2);

endmodule

`default_nettype wire

FILE: sv/s3pwm_duty.sv
// Scaled duty and complementary compare for one phase.
// Divides by the sine scale through a reciprocal, then saturates and, in limited mode, applies deadtime and limits.
// Depends on s3pwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s3pwm_duty #(
    parameter int SINE_SCALE = 32767,
    parameter int PERIOD     = 1000
) (
    input  logic signed [s3pwm_pkg::mag_width(SINE_SCALE):0] numerator,
    input  logic                                             limit_mode,
    input  logic [s3pwm_pkg::DT_W-1:0]                       deadtime_ticks,
    output logic [s3pwm_pkg::OUT_W-1:0]                      duty,
    output logic [s3pwm_pkg::OUT_W-1:0]                      low_side
);

    localparam int XW     = s3pwm_pkg::mag_width(SINE_SCALE);
    localparam int NW     = XW + 1;
    localparam int MW     = XW + 1;
    localparam int FW     = XW + MW;
    localparam int K      = XW + $clog2(SINE_SCALE);
    localparam int QW     = s3pwm_pkg::QUOT_W;
    localparam int DW     = $clog2(PERIOD + 2048) + 1;
    localparam int OUT_HI = (PERIOD < s3pwm_pkg::OUT_MAX) ? PERIOD : s3pwm_pkg::OUT_MAX;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(SINE_SCALE) - 64'd1) / SINE_SCALE;

    logic                 neg;
    logic [XW-1:0]        mag;
    logic [FW-1:0]        full;
    logic [QW-1:0]        quot;
    logic signed [DW-1:0] quot_s;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] dt;
    logic signed [DW-1:0] max_duty;
    logic signed [DW-1:0] shifted;
    logic signed [DW-1:0] capped;
    logic signed [DW-1:0] limited;
    logic signed [DW-1:0] low_raw;

    function automatic logic [s3pwm_pkg::OUT_W-1:0] sat(input logic signed [DW-1:0] v);
        if (v < 0)
        begin
            return '0;
        end
        else if (v > DW'(OUT_HI))
        begin
            return s3pwm_pkg::OUT_W'(OUT_HI);
        end
        return s3pwm_pkg::OUT_W'(v);
    endfunction

    assign neg    = numerator[NW-1];
    assign mag    = neg ? XW'(-numerator) : XW'(numerator);
    assign full   = FW'(mag) * FW'(RECIP[MW-1:0]);
    assign quot   = full[K +: QW];
    assign quot_s = neg ? -DW'($signed({1'b0, quot})) : DW'($signed({1'b0, quot}));
    assign d      = quot_s + DW'(PERIOD / 2);

    assign dt       = DW'($signed({1'b0, deadtime_ticks}));
    assign max_duty = DW'(PERIOD) - dt - dt;
    assign shifted  = d - dt;
    assign capped   = (shifted >= max_duty) ? max_duty : shifted;
    assign limited  = (capped < dt) ? '0 : capped;
    assign low_raw  = limited + dt + dt;

    assign duty     = sat(limit_mode ? limited : d);
    assign low_side = limit_mode ? sat(low_raw) : '0;

endmodule

`default_nettype wire

FILE: sv/sine_three_phase_pwm_duty_unit.sv
// Three-phase sine PWM duty unit: top level with the pipeline registers.
// Depends on s3pwm_pkg, s3pwm_index, s3pwm_sine and s3pwm_duty.
//
// Each angle item gives one result item with three phase compare values and, in
// limited mode, their complementary compares. An item moves through four registers
// (input, table index, scaled numerator, result), and a new item is accepted every
// cycle while angle_stall is low; the stages advance independently, so bubbles
// close up while the result side stalls. The deadtime is written through
// cfg_write/cfg_data and resets to 80 ticks. The sine table is constant logic
// built at elaboration; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sine_three_phase_pwm_duty_unit #(
    parameter int TABLE_SIZE = 256,
    parameter int SINE_SCALE = 32767,
    parameter int PERIOD     = 1000
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [s3pwm_pkg::DT_W-1:0]    cfg_data,
    input  logic                          angle_valid,
    output logic                          angle_stall,
    input  s3pwm_pkg::in_item_t           angle_item,
    output logic                          duty_valid,
    input  logic                          duty_stall,
    output s3pwm_pkg::out_item_t          duty_item
);

    localparam int IW     = $clog2(TABLE_SIZE);
    localparam int NW     = s3pwm_pkg::mag_width(SINE_SCALE) + 1;
    localparam int OUT_HI = (PERIOD < s3pwm_pkg::OUT_MAX) ? PERIOD : s3pwm_pkg::OUT_MAX;

    logic [s3pwm_pkg::DT_W-1:0] deadtime_reg;

    logic                s1_valid_reg;
    s3pwm_pkg::in_item_t s1_item_reg;

    logic                              s2_valid_reg;
    logic [2:0][IW-1:0]                s2_idx_reg;
    logic [s3pwm_pkg::LEVEL_W-1:0]     s2_level_reg;
    logic                              s2_limit_reg;

    logic                 s3_valid_reg;
    logic signed [NW-1:0] s3_num_reg [3];
    logic                 s3_limit_reg;

    logic                 out_valid_reg;
    s3pwm_pkg::out_item_t out_item_reg;
    s3pwm_pkg::out_item_t out_item_next;

    logic [2:0][IW-1:0]               phase_idx;
    logic signed [NW-1:0]             num [3];
    logic [s3pwm_pkg::OUT_W-1:0]      duty [3];
    logic [s3pwm_pkg::OUT_W-1:0]      low [3];

    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;

    assign out_free = !out_valid_reg || !duty_stall;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign angle_stall = !s1_free;
    assign duty_valid  = out_valid_reg;
    assign duty_item   = out_item_reg;

    s3pwm_index #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_index (
        .angle_turns (s1_item_reg.angle_turns),
        .phase_idx   (phase_idx)
    );

    genvar j;
    for (j = 0; j < 3; j++)
    begin : g_phase
        s3pwm_sine #(
            .TABLE_SIZE (TABLE_SIZE),
            .SINE_SCALE (SINE_SCALE)
        ) u_sine (
            .idx         (s2_idx_reg[j]),
            .drive_level (s2_level_reg),
            .numerator   (num[j])
        );

        s3pwm_duty #(
            .SINE_SCALE (SINE_SCALE),
            .PERIOD     (PERIOD)
        ) u_duty (
            .numerator      (s3_num_reg[j]),
            .limit_mode     (s3_limit_reg),
            .deadtime_ticks (deadtime_reg),
            .duty           (duty[j]),
            .low_side       (low[j])
        );
    end

    always_comb
    begin
        out_item_next.duty_a     = duty[0];
        out_item_next.duty_b     = duty[1];
        out_item_next.duty_c     = duty[2];
        out_item_next.low_side_a = low[0];
        out_item_next.low_side_b = low[1];
        out_item_next.low_side_c = low[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadtime_reg  <= s3pwm_pkg::DEADTIME_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                deadtime_reg <= cfg_data;
            end
            if (s1_free)
            begin
                s1_valid_reg <= angle_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && angle_valid)
        begin
            s1_item_reg <= angle_item;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_idx_reg   <= phase_idx;
            s2_level_reg <= s1_item_reg.drive_level;
            s2_limit_reg <= s1_item_reg.limit_mode;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_num_reg[0] <= num[0];
            s3_num_reg[1] <= num[1];
            s3_num_reg[2] <= num[2];
            s3_limit_reg  <= s2_limit_reg;
        end
        if (out_free && s3_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && !angle_stall |=> s1_valid_reg)
        else $error("accepted item did not reach the input register");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_idx_reg[0] < TABLE_SIZE) && (s2_idx_reg[1] < TABLE_SIZE)
                         && (s2_idx_reg[2] < TABLE_SIZE))
        else $error("phase index outside the sine table");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("result raised without an item in the numerator stage");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.duty_a <= OUT_HI) && (out_item_reg.duty_b <= OUT_HI)
                          && (out_item_reg.duty_c <= OUT_HI)
                          && (out_item_reg.low_side_a <= OUT_HI)
                          && (out_item_reg.low_side_b <= OUT_HI)
                          && (out_item_reg.low_side_c <= OUT_HI))
        else $error("compare value above the saturation limit");

endmodule

`default_nettype wire

FILE: bench/sine_three_phase_pwm_duty_unit_tb.sv
// Self-checking bench for sine_three_phase_pwm_duty_unit: predicts the phase compares
// from its own sine table and checks every result item, with random idling on both sides.
// Depends on s3pwm_pkg and the duty unit RTL.
`timescale 1ns / 1ps

module sine_three_phase_pwm_duty_unit_tb;

    localparam int LUT_N      = 256;
    localparam int SINE_FULL  = 32767;
    localparam int PWM_PERIOD = 1000;
    localparam int WAIT_MAX   = 17;
    localparam int LONG_HOLD  = 120;
    localparam int OW         = s3pwm_pkg::OUT_W;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_write   = 1'b0;
    logic [s3pwm_pkg::DT_W-1:0] cfg_data    = '0;
    logic                       angle_valid = 1'b0;
    logic                       angle_stall;
    s3pwm_pkg::in_item_t        angle_item  = '0;
    logic                       duty_valid;
    logic                       duty_stall  = 1'b0;
    s3pwm_pkg::out_item_t       duty_item;

    int                         sine_lut [LUT_N];
    logic [s3pwm_pkg::DT_W-1:0] dead_ticks = s3pwm_pkg::DEADTIME_RESET;
    s3pwm_pkg::in_item_t        angle_pending_q [$];
    s3pwm_pkg::out_item_t       duty_expect_q [$];
    int unsigned     gap_left   = 0;
    int unsigned     stall_left = 0;
    int unsigned     hold_left  = 0;
    logic            hold_kick  = 1'b0;
    logic            send_calm  = 1'b0;
    logic            recv_calm  = 1'b0;
    int              mismatches = 0;
    string           field_name [6] = '{"duty_a", "duty_b", "duty_c",
                                        "low_side_a", "low_side_b", "low_side_c"};

    sine_three_phase_pwm_duty_unit #(
        .TABLE_SIZE(LUT_N),
        .SINE_SCALE(SINE_FULL),
        .PERIOD    (PWM_PERIOD)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .angle_valid(angle_valid),
        .angle_stall(angle_stall),
        .angle_item (angle_item),
        .duty_valid (duty_valid),
        .duty_stall (duty_stall),
        .duty_item  (duty_item)
    );

    always #5 clk = ~clk;

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic longint unsigned taylor_sine_q30(input longint unsigned p);
        longint unsigned x, x2, term, pos, negs, n;
        x = (p * s3pwm_pkg::HALF_PI_Q40 / LUT_N + 512) >> 10;
        x2 = (x * x) >> 30;
        term = x;
        pos = x;
        negs = 0;
        for (n = 1; n <= 9; n++)
        begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                negs += term;
            else
                pos += term;
        end
        if (negs >= pos)
            return 0;
        pos -= negs;
        if (pos > (64'd1 << 30))
            pos = 64'd1 << 30;
        return pos;
    endfunction

    function automatic void fill_sine_lut();
        longint unsigned k, p, mag;
        logic            neg;
        for (k = 0; k < LUT_N; k++)
        begin
            p = 4 * k;
            neg = 1'b0;
            if (p >= 2 * LUT_N)
            begin
                neg = 1'b1;
                p -= 2 * LUT_N;
            end
            if (p > LUT_N)
                p = 2 * LUT_N - p;
            if (p == 0)
                mag = 0;
            else if (p == LUT_N)
                mag = SINE_FULL;
            else if (3 * p == LUT_N)
                mag = (SINE_FULL + 1) / 2;
            else
                mag = (SINE_FULL * taylor_sine_q30(p) + (64'd1 << 29)) >> 30;
            sine_lut[k] = neg ? -int'(mag) : int'(mag);
        end
    endfunction

    function automatic logic [OW-1:0] clip_count(input longint v);
        longint hi;
        hi = (PWM_PERIOD < s3pwm_pkg::OUT_MAX) ? PWM_PERIOD : s3pwm_pkg::OUT_MAX;
        if (v < 0)
            v = 0;
        if (v > hi)
            v = hi;
        return v[OW-1:0];
    endfunction

    function automatic s3pwm_pkg::out_item_t three_phase_duties(input s3pwm_pkg::in_item_t it);
        logic [31:0]          raw;
        longint unsigned      mag;
        longint               idx, s, d, dt, lvl, top;
        int                   offs [3];
        logic [OW-1:0]        duty [3];
        logic [OW-1:0]        low [3];
        s3pwm_pkg::out_item_t res;
        raw = it.angle_turns;
        mag = raw[31] ? (64'h1_0000_0000 - raw) : raw;
        idx = longint'((mag * LUT_N + 32768) >> 16);
        if (raw[31])
            idx = -idx;
        idx = idx % LUT_N;
        if (idx < 0)
            idx += LUT_N;
        offs = '{0, LUT_N / 3, (2 * LUT_N + 1) / 3};
        dt = longint'(dead_ticks);
        lvl = longint'(it.drive_level);
        for (int j = 0; j < 3; j++)
        begin
            s = sine_lut[(idx + offs[j]) % LUT_N];
            d = (s * s3pwm_pkg::LEVEL_GAIN * lvl + SINE_FULL / 2) / SINE_FULL
                + PWM_PERIOD / 2;
            if (it.limit_mode)
            begin
                top = PWM_PERIOD - 2 * dt;
                d -= dt;
                if (d >= top)
                    d = top;
                if (d < dt)
                    d = 0;
                low[j] = clip_count(d + 2 * dt);
            end
            else
                low[j] = '0;
            duty[j] = clip_count(d);
        end
        res.duty_a = duty[0];
        res.duty_b = duty[1];
        res.duty_c = duty[2];
        res.low_side_a = low[0];
        res.low_side_b = low[1];
        res.low_side_c = low[2];
        return res;
    endfunction

    function automatic int unsigned draw_wait(input logic calm);
        return calm ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic busy;
        if (!rst_n)
        begin
            angle_valid <= 1'b0;
            angle_item <= '0;
            gap_left <= 0;
        end
        else
        begin
            busy = angle_valid && angle_stall;
            if (angle_valid && !angle_stall)
                duty_expect_q.push_back(three_phase_duties(angle_item));
            if (!busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    angle_valid <= 1'b0;
                end
                else if (angle_pending_q.size() != 0)
                begin
                    angle_item <= angle_pending_q.pop_front();
                    angle_valid <= 1'b1;
                    gap_left <= draw_wait(send_calm);
                end
                else
                    angle_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : monitor
        int unsigned          wait_next;
        s3pwm_pkg::out_item_t want;
        s3pwm_pkg::out_item_t got;
        if (!rst_n)
        begin
            duty_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            wait_next = stall_left;
            if (duty_valid && !duty_stall)
            begin
                got = duty_item;
                if (duty_expect_q.size() == 0)
                    note_mismatch("result item with no item outstanding");
                else
                begin
                    want = duty_expect_q.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (got[(5 - f) * OW +: OW] !== want[(5 - f) * OW +: OW])
                            note_mismatch($sformatf("%s got %0d want %0d", field_name[f],
                                got[(5 - f) * OW +: OW], want[(5 - f) * OW +: OW]));
                end
                wait_next = draw_wait(recv_calm);
            end
            else if (stall_left != 0)
                wait_next = stall_left - 1;
            stall_left <= wait_next;
            duty_stall <= (wait_next != 0) || (hold_left != 0);
        end
    end

    task automatic queue_angle(input logic [31:0] ang, input int unsigned lvl, input logic lim);
        s3pwm_pkg::in_item_t it;
        it.angle_turns = ang;
        it.drive_level = lvl[s3pwm_pkg::LEVEL_W-1:0];
        it.limit_mode = lim;
        angle_pending_q.push_back(it);
    endtask

    task automatic queue_random(input int count);
        logic [31:0] ang;
        int unsigned lvl;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: ang = $urandom;
                1: ang = $urandom_range(0, 524288) - 262144;
                2: ang = ($urandom_range(0, 1023) * 256 + 128 + $urandom_range(0, 2) - 1)
                         * ($urandom_range(0, 1) ? 1 : -1);
                default: ang = ($urandom_range(0, 2047) - 1024) * 256;
            endcase
            lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127)
                                              : $urandom_range(0, 100);
            queue_angle(ang, lvl, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (angle_pending_q.size() != 0 || angle_valid || duty_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_deadtime(input logic [s3pwm_pkg::DT_W-1:0] v);
        drain();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        dead_ticks = v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        fill_sine_lut();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset deadtime: quarter, half, third and full turns, rounding edges, extremes
        queue_angle(32'd0, 0, 1'b0);
        queue_angle(32'd0, 100, 1'b0);
        queue_angle(32'd0, 100, 1'b1);
        queue_angle(32'd16384, 100, 1'b0);
        queue_angle(32'd16384, 100, 1'b1);
        queue_angle(-32'sd16384, 100, 1'b1);
        queue_angle(32'd32768, 127, 1'b1);
        queue_angle(-32'sd32768, 127, 1'b0);
        queue_angle(32'd128, 50, 1'b1);
        queue_angle(-32'sd128, 50, 1'b1);
        queue_angle(32'd127, 50, 1'b0);
        queue_angle(-32'sd127, 50, 1'b1);
        queue_angle(32'd65536, 100, 1'b1);
        queue_angle(-32'sd65536, 100, 1'b0);
        queue_angle(32'h7FFF_FFFF, 127, 1'b1);
        queue_angle(32'h8000_0000, 127, 1'b0);
        queue_angle(32'h8000_0000, 0, 1'b1);
        queue_angle(32'h0000_FF80, 100, 1'b1);
        queue_angle(32'd21845, 100, 1'b1);
        queue_angle(-32'sd21845, 100, 1'b1);
        queue_angle(32'd43690, 101, 1'b0);
        queue_angle(32'hFFFF_FFFF, 127, 1'b1);
        queue_angle(32'd49152, 100, 1'b1);

        set_deadtime(8'd0);
        queue_random(110);

        set_deadtime(8'd255);
        recv_calm <= 1'b1;
        queue_random(110);

        // fill the pipeline against a long result stall
        set_deadtime(8'($urandom_range(0, 255)));
        recv_calm <= 1'b0;
        send_calm <= 1'b1;
        queue_random(60);
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;

        set_deadtime(8'd1);
        send_calm <= 1'b0;
        queue_random(110);

        set_deadtime(8'($urandom_range(0, 255)));
        queue_random(100);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("sine_three_phase_pwm_duty_unit regression: pass");
        else
            $display("sine_three_phase_pwm_duty_unit regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("sine_three_phase_pwm_duty_unit regression: fail");
        $finish;
    end

endmodule
